// File: rtl/aligned_bitmap_block_allocator_top_macros.svh
// Assertion macros for the aligned bitmap block allocator.
// Used by the top level; defining ASSERT_OFF removes the checks.
`ifndef ALIGNED_BITMAP_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define ALIGNED_BITMAP_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define BMA_ASSERT_IMP(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
`define BMA_ASSERT_NXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`else
`define BMA_ASSERT_IMP(lbl, clk, rst_n, a, b)
`define BMA_ASSERT_NXT(lbl, clk, rst_n, a, b)
`endif
`endif

// File: rtl/bmalloc_pkg.sv
// Shared constants, types and helper functions of the bitmap allocator.
// No dependencies.
package bmalloc_pkg;
	localparam int MAP_BITS  = 3584;
	localparam int WORD_W    = 64;
	localparam int NUM_WORDS = MAP_BITS / WORD_W;
	localparam int WIDX_W    = $clog2(NUM_WORDS);
	localparam int BIT_W     = $clog2(WORD_W);
	localparam int BLK_W     = 12;
	localparam int ALIGN     = 16;
	localparam int CHUNKS    = WORD_W / ALIGN;
	localparam int CNT_W     = $clog2(ALIGN + 1);
	localparam int BASE      = 512;

	localparam logic [1:0] RES_FAIL  = 2'd0;
	localparam logic [1:0] RES_ALLOC = 2'd1;
	localparam logic [1:0] RES_FREE  = 2'd2;

	localparam logic OP_ALLOC = 1'b0;

	typedef struct packed {
		logic       load;
		logic       scan_init;
		logic       scan_step;
		logic       set_range;
		logic       rmw_wr;
		logic       clear_all;
		logic       res_load;
		logic [1:0] res_kind;
	} cmd_t;

	typedef struct packed {
		logic is_alloc;
		logic want_zero;
		logic free_empty;
		logic range_nonempty;
		logic found;
		logic exhausted;
		logic at_last;
	} sts_t;

	// Number of free (zero) blocks at the low end of an aligned chunk.
	function automatic logic [CNT_W-1:0] free_lead(input logic [ALIGN-1:0] w);
		logic [CNT_W-1:0] n;
		n = CNT_W'(ALIGN);
		for (int i = ALIGN - 1; i >= 0; i--) begin
			if (w[i]) n = CNT_W'(i);
		end
		return n;
	endfunction
endpackage

// File: rtl/bmalloc_in_if.sv
// Request channel of the bitmap allocator: valid/ready plus request fields.
// Depends on nothing.
interface bmalloc_in_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [11:0] block_count;
	logic [11:0] free_start;
	modport source(output valid, op, block_count, free_start, input ready);
	modport sink(input valid, op, block_count, free_start, output ready);
endinterface

// File: rtl/bmalloc_out_if.sv
// Response channel of the bitmap allocator: valid/ready plus result fields.
// Depends on nothing.
interface bmalloc_out_if;
	logic        valid;
	logic        ready;
	logic        status;
	logic [11:0] alloc_offset;
	logic [11:0] used_blocks;
	logic        page_empty;
	modport source(output valid, status, alloc_offset, used_blocks, page_empty, input ready);
	modport sink(input valid, status, alloc_offset, used_blocks, page_empty, output ready);
endinterface

// File: rtl/bmalloc_dp.sv
// Datapath: bitmap word memory, first-fit scan, range read-modify-write, result registers.
// Depends on bmalloc_pkg.
module bmalloc_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  bmalloc_pkg::cmd_t   cmd,
	output bmalloc_pkg::sts_t   sts,
	input  logic                op,
	input  logic [11:0]         block_count,
	input  logic [11:0]         free_start,
	output logic                status,
	output logic [11:0]         alloc_offset,
	output logic [11:0]         used_blocks,
	output logic                page_empty
);
	localparam int BW = bmalloc_pkg::BLK_W;
	localparam int WW = bmalloc_pkg::WORD_W;
	localparam int IW = bmalloc_pkg::WIDX_W;

	logic [WW-1:0] mem [bmalloc_pkg::NUM_WORDS];
	logic [bmalloc_pkg::NUM_WORDS-1:0] vld_q;
	logic [WW-1:0] rd_data_q;
	logic          rd_vld_q;
	logic [IW-1:0] rd_addr;

	logic          op_q;
	logic [BW-1:0] want_q, fstart_q, used_q;
	logic [BW-1:0] run_q, first_q, lo_q, last_q;
	logic [IW-1:0] rd_ptr_q, proc_q, ptr_q;
	logic          data_ok_q;

	logic [WW-1:0] word, mask, mlo, mhi;
	logic [BW-1:0] run_c, first_c, fpos;
	logic          found_c;
	logic [BW:0]   sum;
	logic [bmalloc_pkg::CNT_W-1:0] t;
	logic [BW-1:0] cbase;

	logic signed [BW+1:0] s_f, e_f;
	logic [BW-1:0] f_lo, f_last, a_last;
	logic [BW:0]   add_u;
	logic [BW-1:0] sub_u, used_new;

	assign rd_addr = cmd.scan_step ? rd_ptr_q : ptr_q;

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
		if (cmd.rmw_wr) mem[ptr_q] <= (op_q == bmalloc_pkg::OP_ALLOC) ?
			(word | mask) : (word & ~mask);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= vld_q[rd_addr];
			if (cmd.clear_all) vld_q <= '0;
			else if (cmd.rmw_wr) vld_q[ptr_q] <= 1'b1;
		end
	end

	assign word = rd_vld_q ? rd_data_q : '0;

	// Chunk-wise first-fit: a run may only open at the bottom of an aligned chunk.
	always_comb begin
		run_c   = run_q;
		first_c = first_q;
		found_c = 1'b0;
		fpos    = first_q;
		sum     = '0;
		t       = '0;
		cbase   = '0;
		for (int c = 0; c < bmalloc_pkg::CHUNKS; c++) begin
			t     = bmalloc_pkg::free_lead(word[c*bmalloc_pkg::ALIGN +: bmalloc_pkg::ALIGN]);
			cbase = BW'(proc_q) * BW'(WW) + BW'(c * bmalloc_pkg::ALIGN);
			if (!found_c) begin
				if (run_c == '0 && t != '0) first_c = cbase;
				sum = {1'b0, run_c} + (BW+1)'(t);
				if (t != '0 && sum >= {1'b0, want_q}) begin
					found_c = 1'b1;
					fpos    = first_c;
				end else if (t == bmalloc_pkg::CNT_W'(bmalloc_pkg::ALIGN)) begin
					run_c = sum[BW-1:0];
				end else begin
					run_c = '0;
				end
			end
		end
	end

	assign a_last = fpos + want_q - BW'(1);

	// Free range clipped to the map.
	assign s_f    = $signed({2'b00, fstart_q}) - (BW+2)'(bmalloc_pkg::BASE);
	assign e_f    = s_f + $signed({2'b00, want_q});
	assign f_lo   = (s_f < 0) ? '0 : s_f[BW-1:0];
	assign f_last = (e_f > (BW+2)'(bmalloc_pkg::MAP_BITS)) ?
		BW'(bmalloc_pkg::MAP_BITS - 1) : (e_f[BW-1:0] - BW'(1));

	assign add_u    = {1'b0, used_q} + {1'b0, want_q};
	assign sub_u    = (used_q > want_q) ? (used_q - want_q) : '0;
	assign used_new = (cmd.res_kind == bmalloc_pkg::RES_ALLOC) ?
		(add_u[BW] ? '1 : add_u[BW-1:0]) :
		((cmd.res_kind == bmalloc_pkg::RES_FREE) ? sub_u : used_q);

	assign mlo  = (ptr_q == lo_q[BW-1 -: IW]) ? ({WW{1'b1}} << lo_q[bmalloc_pkg::BIT_W-1:0]) : '1;
	assign mhi  = (ptr_q == last_q[BW-1 -: IW]) ?
		({WW{1'b1}} >> (~last_q[bmalloc_pkg::BIT_W-1:0])) : '1;
	assign mask = mlo & mhi;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			data_ok_q <= 1'b0;
			rd_ptr_q  <= '0;
			proc_q    <= '0;
		end else begin
			if (cmd.scan_init) begin
				data_ok_q <= 1'b0;
				rd_ptr_q  <= '0;
			end else if (cmd.scan_step) begin
				data_ok_q <= 1'b1;
				proc_q    <= rd_ptr_q;
				if (rd_ptr_q != IW'(bmalloc_pkg::NUM_WORDS - 1)) rd_ptr_q <= rd_ptr_q + IW'(1);
			end
			if (cmd.res_load) used_q <= used_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= op;
			want_q   <= block_count;
			fstart_q <= free_start;
		end
		if (cmd.scan_init) begin
			run_q   <= '0;
			first_q <= '0;
		end else if (cmd.scan_step && data_ok_q) begin
			run_q   <= run_c;
			first_q <= first_c;
		end
		if (cmd.set_range) begin
			lo_q   <= (op_q == bmalloc_pkg::OP_ALLOC) ? fpos : f_lo;
			last_q <= (op_q == bmalloc_pkg::OP_ALLOC) ? a_last : f_last;
			ptr_q  <= (op_q == bmalloc_pkg::OP_ALLOC) ? fpos[BW-1 -: IW] : f_lo[BW-1 -: IW];
		end else if (cmd.rmw_wr) begin
			ptr_q <= ptr_q + IW'(1);
		end
		if (cmd.res_load) begin
			status       <= (cmd.res_kind == bmalloc_pkg::RES_FAIL);
			alloc_offset <= (cmd.res_kind == bmalloc_pkg::RES_ALLOC) ?
				(lo_q + BW'(bmalloc_pkg::BASE)) : '0;
			used_blocks  <= used_new;
			page_empty   <= (cmd.res_kind == bmalloc_pkg::RES_FREE) && (used_new == '0);
		end
	end

	assign sts.is_alloc       = (op_q == bmalloc_pkg::OP_ALLOC);
	assign sts.want_zero      = (want_q == '0);
	assign sts.free_empty     = (sub_u == '0);
	assign sts.range_nonempty = (e_f > 0) && (s_f < (BW+2)'(bmalloc_pkg::MAP_BITS)) && (want_q != '0);
	assign sts.found          = data_ok_q && found_c;
	assign sts.exhausted      = data_ok_q && !found_c &&
		(proc_q == IW'(bmalloc_pkg::NUM_WORDS - 1));
	assign sts.at_last        = (ptr_q == last_q[BW-1 -: IW]);
endmodule

// File: rtl/bmalloc_ctrl.sv
// Controller state machine: sequences load, scan, range update and response.
// Depends on bmalloc_pkg.
module bmalloc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  bmalloc_pkg::sts_t sts,
	output bmalloc_pkg::cmd_t cmd
);
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECIDE = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_RD     = 3'd3;
	localparam logic [2:0] S_WR     = 3'd4;
	localparam logic [2:0] S_RESP   = 3'd5;

	logic [2:0] state_q, state_d;
	logic [1:0] kind_q, kind_d;
	logic       ov_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = ov_q;

	always_comb begin
		state_d = state_q;
		kind_d  = kind_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = in_valid;
				if (in_valid) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (sts.is_alloc) begin
					if (sts.want_zero) begin
						kind_d  = bmalloc_pkg::RES_FAIL;
						state_d = S_RESP;
					end else begin
						cmd.scan_init = 1'b1;
						state_d       = S_SCAN;
					end
				end else begin
					kind_d = bmalloc_pkg::RES_FREE;
					if (sts.free_empty) begin
						cmd.clear_all = 1'b1;
						state_d       = S_RESP;
					end else if (sts.range_nonempty) begin
						cmd.set_range = 1'b1;
						state_d       = S_RD;
					end else begin
						state_d = S_RESP;
					end
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.found) begin
					cmd.set_range = 1'b1;
					kind_d        = bmalloc_pkg::RES_ALLOC;
					state_d       = S_RD;
				end else if (sts.exhausted) begin
					kind_d  = bmalloc_pkg::RES_FAIL;
					state_d = S_RESP;
				end
			end
			S_RD: state_d = S_WR;
			S_WR: begin
				cmd.rmw_wr = 1'b1;
				state_d    = sts.at_last ? S_RESP : S_RD;
			end
			S_RESP: begin
				cmd.res_kind = kind_q;
				if (!ov_q || out_ready) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= bmalloc_pkg::RES_FAIL;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
			if (cmd.res_load) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end
endmodule

// File: rtl/aligned_bitmap_block_allocator_top.sv
// Top level of the aligned first-fit bitmap block allocator.
// Depends on bmalloc_pkg, bmalloc_in_if, bmalloc_out_if, bmalloc_ctrl, bmalloc_dp.
//
// Requests arrive on req (valid/ready): op 0 allocates block_count blocks at the
// first free run that starts on a 16-block boundary, op 1 frees a run at
// free_start (base 512 included). One response per request leaves on rsp.
// One request is in flight at a time; req.ready is high only when idle.
// An allocate walks the 56-word map one 64-bit word per cycle through the
// single read port, then rewrites each touched word in a read state and a
// write state. A free rewrites its touched words the same way; a free that
// empties the page clears the whole map at once through per-word valid bits.
// Reset clears the map valid bits and the used count at once; no clearing pass.
// The response sits in an output register; while rsp.ready is low the block
// can still accept and process the next request and waits only to post it.
`include "aligned_bitmap_block_allocator_top_macros.svh"
module aligned_bitmap_block_allocator_top (
	input logic          clk,
	input logic          arst_n,
	bmalloc_in_if.sink   req,
	bmalloc_out_if.source rsp
);
	bmalloc_pkg::cmd_t cmd;
	bmalloc_pkg::sts_t sts;

	bmalloc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bmalloc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.op           (req.op),
		.block_count  (req.block_count),
		.free_start   (req.free_start),
		.status       (rsp.status),
		.alloc_offset (rsp.alloc_offset),
		.used_blocks  (rsp.used_blocks),
		.page_empty   (rsp.page_empty)
	);

	`BMA_ASSERT_IMP(a_empty_zero, clk, arst_n, rsp.valid && rsp.page_empty, rsp.used_blocks == 12'd0)
	`BMA_ASSERT_IMP(a_fail_no_off, clk, arst_n, rsp.valid && rsp.status, rsp.alloc_offset == 12'd0 && !rsp.page_empty)
	`BMA_ASSERT_NXT(a_busy_after_accept, clk, arst_n, req.valid && req.ready, !req.ready)
endmodule

// File: tb/sv/tb_aligned_bitmap_block_allocator_top.sv
// Self-checking testbench for the aligned first-fit bitmap block allocator.
// Depends on bmalloc_pkg, bmalloc_in_if, bmalloc_out_if and the RTL top level.
// Predicts every response from a private copy of the map and used count.
module tb_aligned_bitmap_block_allocator_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic OP_ALLOC = bmalloc_pkg::OP_ALLOC;
	localparam logic OP_FREE = 1'b1;
	localparam logic ST_DONE = 1'b0;
	localparam logic ST_NO_SPACE = 1'b1;
	localparam int MAP_SIZE = 3584;
	localparam int RUN_ALIGN = 16;
	localparam int RUN_BASE = 512;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 300;

	typedef struct packed {
		logic        status;
		logic [11:0] alloc_offset;
		logic [11:0] used_blocks;
		logic        page_empty;
	} alloc_rsp_t;

	logic clk;
	logic arst_n;
	bmalloc_in_if req_if();
	bmalloc_out_if rsp_if();

	aligned_bitmap_block_allocator_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	bit page_map [MAP_SIZE];
	logic [11:0] page_used;
	alloc_rsp_t expected_rsps [$];
	int live_offsets [$];
	int live_counts [$];
	int mismatch_count;
	int cycle_count;
	bit idling_on;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Applies one request to the private page copy and returns the response.
	function automatic alloc_rsp_t apply_request(logic op, logic [11:0] cnt, logic [11:0] where);
		alloc_rsp_t r;
		int run;
		int first;
		int s;
		r = '0;
		if (op != OP_FREE) begin
			r.status = ST_NO_SPACE;
			run = 0;
			first = 0;
			if (cnt != 0) begin
				for (int p = 0; p < MAP_SIZE; p++) begin
					if (page_map[p]) begin
						run = 0;
						continue;
					end
					if (run == 0) begin
						if (p % RUN_ALIGN != 0) continue;
						first = p;
					end
					run++;
					if (run == int'(cnt)) begin
						for (int k = first; k < first + run; k++) page_map[k] = 1'b1;
						page_used = (int'(page_used) + run > 4095) ? 12'hFFF : page_used + cnt;
						r.status = ST_DONE;
						r.alloc_offset = 12'(first + RUN_BASE);
						live_offsets.push_back(first + RUN_BASE);
						live_counts.push_back(run);
						break;
					end
				end
			end
		end else begin
			s = int'(where) - RUN_BASE;
			for (int i = s; i < s + int'(cnt); i++) begin
				if (i >= 0 && i < MAP_SIZE) page_map[i] = 1'b0;
			end
			page_used = (page_used > cnt) ? page_used - cnt : 12'd0;
			if (page_used == 0) begin
				foreach (page_map[i]) page_map[i] = 1'b0;
				live_offsets.delete();
				live_counts.delete();
				r.page_empty = 1'b1;
			end
		end
		r.used_blocks = page_used;
		return r;
	endfunction

	// Drives one request and holds it until the allocator takes it.
	task automatic send_request(logic op, logic [11:0] cnt, logic [11:0] where);
		req_if.valid <= 1'b1;
		req_if.op <= op;
		req_if.block_count <= cnt;
		req_if.free_start <= where;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
		expected_rsps.push_back(apply_request(op, cnt, where));
		if (idling_on && $urandom_range(0, 99) < 30) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// Waits for every outstanding response, then for any trailing work.
	task automatic wait_idle();
		int n;
		n = 0;
		req_if.valid <= 1'b0;
		while (expected_rsps.size() != 0 && n < 200000) begin
			@(posedge clk);
			n++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic test_directed();
		send_request(OP_ALLOC, 12'd0, 12'd0);
		send_request(OP_ALLOC, 12'd1, 12'd0);
		send_request(OP_ALLOC, 12'd16, 12'hFFF);
		send_request(OP_ALLOC, 12'd17, 12'd0);
		send_request(OP_ALLOC, 12'd3584, 12'd0);
		send_request(OP_ALLOC, 12'hFFF, 12'd0);
		send_request(OP_FREE, 12'd1, 12'd528);
		send_request(OP_FREE, 12'd4, 12'd3000);
		send_request(OP_FREE, 12'd40, 12'd0);
		send_request(OP_ALLOC, 12'd3, 12'd0);
		send_request(OP_FREE, 12'hFFF, 12'd0);
		send_request(OP_ALLOC, 12'd3584, 12'd0);
		send_request(OP_ALLOC, 12'd1, 12'd0);
		send_request(OP_FREE, 12'd64, 12'hFFF);
		send_request(OP_FREE, 12'd3584, 12'd512);
		send_request(OP_FREE, 12'd5, 12'd600);
		send_request(OP_ALLOC, 12'd3585, 12'd0);
		send_request(OP_ALLOC, 12'd2048, 12'd0);
		send_request(OP_ALLOC, 12'd1536, 12'd0);
		send_request(OP_FREE, 12'd2048, 12'd512);
		send_request(OP_ALLOC, 12'd100, 12'd0);
		send_request(OP_FREE, 12'hFFF, 12'hFFF);
	endtask

	// Mostly allocations and frees of runs that are really held, some noise.
	task automatic test_random_traffic(int items);
		int sel;
		int idx;
		logic [11:0] cnt;
		logic [11:0] run_start;
		for (int n = 0; n < items; n++) begin
			sel = $urandom_range(0, 99);
			if (live_offsets.size() != 0 && sel < 40) begin
				idx = $urandom_range(0, live_offsets.size() - 1);
				cnt = 12'(live_counts[idx]);
				run_start = 12'(live_offsets[idx]);
				// The entry goes first, since a free that empties the page clears the lists.
				live_offsets.delete(idx);
				live_counts.delete(idx);
				send_request(OP_FREE, cnt, run_start);
			end else if (sel < 48) begin
				send_request(OP_FREE, 12'($urandom_range(0, 4095)),
					12'($urandom_range(0, 4095)));
			end else begin
				sel = $urandom_range(0, 99);
				if (sel < 70) cnt = 12'($urandom_range(1, 48));
				else if (sel < 90) cnt = 12'($urandom_range(49, 512));
				else if (sel < 97) cnt = 12'($urandom_range(513, 3584));
				else cnt = 12'($urandom_range(0, 1) ? 0 : $urandom_range(3585, 4095));
				send_request(OP_ALLOC, cnt, 12'($urandom_range(0, 4095)));
			end
		end
	endtask

	// Response stall bursts on the receiving side.
	initial begin
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (idling_on && $urandom_range(0, 99) < 25) begin
				rsp_if.ready <= 1'b0;
				repeat ($urandom_range(1, 4) - 1) @(posedge clk);
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		alloc_rsp_t want;
		alloc_rsp_t got;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			got = '{rsp_if.status, rsp_if.alloc_offset, rsp_if.used_blocks, rsp_if.page_empty};
			if (expected_rsps.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected transaction: %p", got);
			end else begin
				want = expected_rsps.pop_front();
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: expected %p, actual %p", want, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		mismatch_count = 0;
		cycle_count = 0;
		idling_on = 1'b1;
		page_used = '0;
		foreach (page_map[i]) page_map[i] = 1'b0;
		arst_n <= 1'b0;
		req_if.valid <= 1'b0;
		req_if.op <= OP_ALLOC;
		req_if.block_count <= '0;
		req_if.free_start <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_traffic(420);
		idling_on = 1'b0;
		test_random_traffic(130);
		wait_idle();
		if (mismatch_count == 0 && expected_rsps.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule

// File: files.f
+incdir+rtl
rtl/bmalloc_pkg.sv
rtl/bmalloc_in_if.sv
rtl/bmalloc_out_if.sv
rtl/bmalloc_dp.sv
rtl/bmalloc_ctrl.sv
rtl/aligned_bitmap_block_allocator_top.sv
tb/sv/tb_aligned_bitmap_block_allocator_top.sv
